### hdl/dtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

  // Tile geometry in pixels. Both are powers of two, so pixel-to-tile
  // conversion is a plain shift.
  localparam int CELL_WIDTH  = 8;
  localparam int CELL_HEIGHT = 8;
  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int MAP_DEPTH   = 4096;

  // Each map is kept as words of tile bits.
  localparam int WORD_BITS  = 64;
  localparam int WORD_LOG   = $clog2(WORD_BITS);
  localparam int NUM_WORDS  = MAP_DEPTH / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int IDX_W      = $clog2(MAP_DEPTH);
  localparam int WORD_BYTES = WORD_BITS / 8;

  localparam int GRID_W = 7;
  localparam int TILE_W = 6;
  localparam int CNT_W  = 13;
  localparam int CMD_W  = 3;
  localparam int PIX_W  = 16;
  localparam int CELL_W = 8;

  typedef logic [CMD_W-1:0]            cmd_t;
  typedef logic signed [PIX_W-1:0]     pix_t;
  typedef logic [CELL_W-1:0]           cell_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [GRID_W-1:0]           grid_t;
  typedef logic [WORD_BITS-1:0]        word_t;

  localparam cmd_t CMD_MARK_RECT = 3'd0;
  localparam cmd_t CMD_MARK_CELL = 3'd1;
  localparam cmd_t CMD_MARK_ALL  = 3'd2;
  localparam cmd_t CMD_SWAP      = 3'd3;
  localparam cmd_t CMD_QUERY     = 3'd4;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

endpackage

`default_nettype wire

### hdl/dtt_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtt_cmd_if;
  import dtt_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  pix_t  rect_x;
  pix_t  rect_y;
  pix_t  rect_w;
  pix_t  rect_h;
  cell_t cell_col;
  cell_t cell_row;

  modport source (
    output valid, cmd, rect_x, rect_y, rect_w, rect_h, cell_col, cell_row,
    input  ready
  );

  modport sink (
    input  valid, cmd, rect_x, rect_y, rect_w, rect_h, cell_col, cell_row,
    output ready
  );

endinterface

`default_nettype wire

### hdl/dtt_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtt_res_if;
  import dtt_pkg::*;

  logic valid;
  logic ready;
  logic prev_dirty;
  logic curr_marked;
  cnt_t curr_total;
  cnt_t prev_total;
  logic all_dirty;

  modport source (
    output valid, prev_dirty, curr_marked, curr_total, prev_total, all_dirty,
    input  ready
  );

  modport sink (
    input  valid, prev_dirty, curr_marked, curr_total, prev_total, all_dirty,
    output ready
  );

endinterface

`default_nettype wire

### hdl/dirty_tile_tracker.sv
// Dirty-tile tracker: two bitmaps of screen tiles, current and previous frame.
// Commands come in on in_ch (valid/ready); each command gives exactly one
// result transfer on out_ch carrying the queried bits, both tile totals and
// the sticky all-dirty flag as they stand after the command.
// Grid size is set through the APB-style cfg_ port (grid_cols at 0x0,
// grid_rows at 0x4); a write clears both maps, counts and the flag; the user
// must only write while the block is idle, as the block does not enforce it.
// One command is worked on at a time. mark_rect reads each map word of
// each tile row, then modifies and writes it back through the single
// memory port; mark_all writes (cols*rows)/64 words rounded up, one word
// written per cycle.
// in_ch.ready is high whenever no command is in progress; a new command is
// taken while an earlier result still waits in the output register, and it
// finishes only once that register is free, so a stalled receiver holds
// everything without loss.
// After reset both maps read as zero through per-word valid bits, so no
// clearing pass is needed; the block takes commands at once.
`timescale 1ns / 1ps
`default_nettype none

module dirty_tile_tracker (
  input  wire                        clk,
  input  wire                        rst_n,
  dtt_cmd_if.sink                    in_ch,
  dtt_res_if.source                  out_ch,
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire [2:0]                  cfg_paddr,
  input  wire [31:0]                 cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import dtt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_BASE = 4'd2;
  localparam logic [3:0] S_ROW  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_FILL = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QOUT = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam word_t ONES = {WORD_BITS{1'b1}};

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [3:0]           state_r, state_nxt;
  grid_t                cols_r, cols_nxt;
  grid_t                rows_r, rows_nxt;
  logic                 cur_b_r, cur_b_nxt;
  cnt_t                 curr_cnt_r, curr_cnt_nxt;
  cnt_t                 prev_cnt_r, prev_cnt_nxt;
  logic                 full_r, full_nxt;
  logic [NUM_WORDS-1:0] vld_a_r, vld_a_nxt;
  logic [NUM_WORDS-1:0] vld_b_r, vld_b_nxt;
  logic                 pc_pend_r, pc_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Command and walk registers
  cmd_t                 cmd_r, cmd_nxt;
  pix_t                 x_r, x_nxt;
  pix_t                 y_r, y_nxt;
  pix_t                 w_r, w_nxt;
  pix_t                 h_r, h_nxt;
  cell_t                col_r, col_nxt;
  cell_t                row_r, row_nxt;
  logic [TILE_W-1:0]    cx0_r, cx0_nxt;
  logic [TILE_W-1:0]    cx1_r, cx1_nxt;
  logic [TILE_W-1:0]    cy_r, cy_nxt;
  logic [TILE_W-1:0]    cy1_r, cy1_nxt;
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [IDX_W-1:0]     lo_r, lo_nxt;
  logic [IDX_W-1:0]     hi_r, hi_nxt;
  logic [WADDR_W-1:0]   wcur_r, wcur_nxt;
  cnt_t                 total_r, total_nxt;
  logic                 pbit_r, pbit_nxt;
  logic                 cbit_r, cbit_nxt;
  logic [3:0]           pc_bytes_r [WORD_BYTES];
  logic [3:0]           pc_bytes_nxt [WORD_BYTES];

  // Output register
  logic                 o_prev_r, o_curr_r, o_all_r;
  cnt_t                 o_ctot_r, o_ptot_r;

  // Memories
  word_t                mem_a [NUM_WORDS];
  word_t                mem_b [NUM_WORDS];
  word_t                rdata_a_r, rdata_b_r;
  logic                 rvld_a_r, rvld_b_r;
  logic                 we_a, we_b;
  word_t                wdata;

  // Datapath intermediates
  logic                 cfg_we;
  grid_t                cfg_val;
  logic                 grid_ok;
  logic signed [17:0]   max_x, max_y, x_end, y_end, x1, y1, x2, y2;
  logic                 rect_ok, cell_ok;
  logic [IDX_W-1:0]     q_idx, row_lo, row_hi;
  word_t                cur_old, mask, new_bits, fill_mask;
  logic [WORD_LOG-1:0]  lo_b, hi_b;
  logic [WADDR_W-1:0]   fill_last;
  logic [6:0]           pc_sum;
  logic                 load_out;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  // Oversized values saturate to the grid limit.
  assign cfg_val    = (cfg_pwdata[6:0] > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS)
                                                            : cfg_pwdata[6:0];

  always_comb begin
    if (cfg_paddr[2] == REG_GRID_ROWS) begin
      cfg_prdata = 32'(rows_r);
    end else begin
      cfg_prdata = 32'(cols_r);
    end
  end

  assign grid_ok = (cols_r != '0) && (rows_r != '0);

  // ---------------------------------------------------------------------
  // Rectangle clipping and tile index arithmetic
  // ---------------------------------------------------------------------
  always_comb begin
    max_x = $signed(18'(cols_r) * 18'(CELL_WIDTH)) - 18'sd1;
    max_y = $signed(18'(rows_r) * 18'(CELL_HEIGHT)) - 18'sd1;
    x_end = 18'(x_r) + 18'(w_r) - 18'sd1;
    y_end = 18'(y_r) + 18'(h_r) - 18'sd1;
    x1    = x_r[PIX_W-1] ? 18'sd0 : 18'(x_r);
    y1    = y_r[PIX_W-1] ? 18'sd0 : 18'(y_r);
    x2    = (x_end > max_x) ? max_x : x_end;
    y2    = (y_end > max_y) ? max_y : y_end;
    rect_ok = (w_r > 16'sd0) && (h_r > 16'sd0) && grid_ok && (x1 <= x2) && (y1 <= y2);
    cell_ok = (col_r < CELL_W'(cols_r)) && (row_r < CELL_W'(rows_r));
    q_idx   = IDX_W'(13'(row_r[TILE_W-1:0]) * 13'(cols_r) + 13'(col_r[TILE_W-1:0]));
    row_lo  = base_r + IDX_W'(cx0_r);
    row_hi  = base_r + IDX_W'(cx1_r);
  end

  // ---------------------------------------------------------------------
  // Word modify: the current map's word as read, the run of tiles to set
  // in it, the bits that go from clear to set, their per-byte counts and
  // the fill mask for mark_all.
  always_comb begin
    if (cur_b_r) begin
      cur_old = rvld_b_r ? rdata_b_r : '0;
    end else begin
      cur_old = rvld_a_r ? rdata_a_r : '0;
    end
    lo_b     = (wcur_r == lo_r[IDX_W-1:WORD_LOG]) ? lo_r[WORD_LOG-1:0] : '0;
    hi_b     = (wcur_r == hi_r[IDX_W-1:WORD_LOG]) ? hi_r[WORD_LOG-1:0] : '1;
    mask     = (ONES << lo_b) & (ONES >> (WORD_LOG'(WORD_BITS - 1) - hi_b));
    new_bits = mask & ~cur_old;
    // mark_all fills whole words up to the last one, which is partial
    // unless the tile total is a multiple of the word size.
    fill_last = WADDR_W'((total_r - 13'd1) >> WORD_LOG);
    if ((wcur_r != fill_last) || (total_r[WORD_LOG-1:0] == '0)) begin
      fill_mask = ONES;
    end else begin
      fill_mask = ~(ONES << total_r[WORD_LOG-1:0]);
    end
    for (int i = 0; i < WORD_BYTES; i++) begin
      pc_bytes_nxt[i] = pop8(new_bits[8*i +: 8]);
    end
    pc_sum = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      pc_sum = pc_sum + 7'(pc_bytes_r[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    cols_nxt     = cols_r;
    rows_nxt     = rows_r;
    cur_b_nxt    = cur_b_r;
    curr_cnt_nxt = curr_cnt_r;
    prev_cnt_nxt = prev_cnt_r;
    full_nxt     = full_r;
    vld_a_nxt    = vld_a_r;
    vld_b_nxt    = vld_b_r;
    pc_pend_nxt  = 1'b0;
    cmd_nxt      = cmd_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    cx0_nxt      = cx0_r;
    cx1_nxt      = cx1_r;
    cy_nxt       = cy_r;
    cy1_nxt      = cy1_r;
    base_nxt     = base_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    wcur_nxt     = wcur_r;
    total_nxt    = total_r;
    pbit_nxt     = pbit_r;
    cbit_nxt     = cbit_r;
    we_a         = 1'b0;
    we_b         = 1'b0;
    wdata        = cur_old | mask;

    // New-tile counts from the previous word write are added here.
    if (pc_pend_r) begin
      curr_cnt_nxt = curr_cnt_r + CNT_W'(pc_sum);
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          x_nxt     = in_ch.rect_x;
          y_nxt     = in_ch.rect_y;
          w_nxt     = in_ch.rect_w;
          h_nxt     = in_ch.rect_h;
          col_nxt   = in_ch.cell_col;
          row_nxt   = in_ch.cell_row;
          pbit_nxt  = 1'b0;
          cbit_nxt  = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_MARK_RECT: begin
            cx0_nxt = TILE_W'($unsigned(x1) / CELL_WIDTH);
            cx1_nxt = TILE_W'($unsigned(x2) / CELL_WIDTH);
            cy_nxt  = TILE_W'($unsigned(y1) / CELL_HEIGHT);
            cy1_nxt = TILE_W'($unsigned(y2) / CELL_HEIGHT);
            if (rect_ok) begin
              state_nxt = S_BASE;
            end
          end
          CMD_MARK_CELL: begin
            cx0_nxt = col_r[TILE_W-1:0];
            cx1_nxt = col_r[TILE_W-1:0];
            cy_nxt  = row_r[TILE_W-1:0];
            cy1_nxt = row_r[TILE_W-1:0];
            if (cell_ok) begin
              state_nxt = S_BASE;
            end
          end
          CMD_MARK_ALL: begin
            full_nxt = 1'b1;
            if (grid_ok) begin
              total_nxt    = CNT_W'(cols_r) * CNT_W'(rows_r);
              curr_cnt_nxt = CNT_W'(cols_r) * CNT_W'(rows_r);
              wcur_nxt     = '0;
              state_nxt    = S_FILL;
            end
          end
          CMD_SWAP: begin
            if (grid_ok) begin
              // The previous map becomes current and starts out empty.
              cur_b_nxt    = ~cur_b_r;
              prev_cnt_nxt = curr_cnt_r;
              curr_cnt_nxt = '0;
              if (cur_b_r) begin
                vld_a_nxt = '0;
              end else begin
                vld_b_nxt = '0;
              end
            end
          end
          CMD_QUERY: begin
            if (cell_ok) begin
              lo_nxt    = q_idx;
              wcur_nxt  = q_idx[IDX_W-1:WORD_LOG];
              state_nxt = S_QRD;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_BASE: begin
        base_nxt  = IDX_W'(13'(cy_r) * 13'(cols_r));
        state_nxt = S_ROW;
      end
      S_ROW: begin
        lo_nxt    = row_lo;
        hi_nxt    = row_hi;
        wcur_nxt  = row_lo[IDX_W-1:WORD_LOG];
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        we_a        = ~cur_b_r;
        we_b        = cur_b_r;
        pc_pend_nxt = 1'b1;
        if (wcur_r != hi_r[IDX_W-1:WORD_LOG]) begin
          wcur_nxt  = wcur_r + 1'b1;
          state_nxt = S_RD;
        end else if (cy_r != cy1_r) begin
          cy_nxt    = cy_r + 1'b1;
          base_nxt  = base_r + IDX_W'(cols_r);
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        we_a  = ~cur_b_r;
        we_b  = cur_b_r;
        wdata = fill_mask;
        if (wcur_r == fill_last) begin
          state_nxt = S_DONE;
        end else begin
          wcur_nxt = wcur_r + 1'b1;
        end
      end
      S_QRD: begin
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (cur_b_r) begin
          cbit_nxt = rvld_b_r & rdata_b_r[lo_r[WORD_LOG-1:0]];
          pbit_nxt = rvld_a_r & rdata_a_r[lo_r[WORD_LOG-1:0]];
        end else begin
          cbit_nxt = rvld_a_r & rdata_a_r[lo_r[WORD_LOG-1:0]];
          pbit_nxt = rvld_b_r & rdata_b_r[lo_r[WORD_LOG-1:0]];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (we_a) begin
      vld_a_nxt[wcur_r] = 1'b1;
    end
    if (we_b) begin
      vld_b_nxt[wcur_r] = 1'b1;
    end

    // A grid size write wipes every map and count.
    if (cfg_we) begin
      if (cfg_paddr[2] == REG_GRID_ROWS) begin
        rows_nxt = cfg_val;
      end else begin
        cols_nxt = cfg_val;
      end
      cur_b_nxt    = 1'b0;
      curr_cnt_nxt = '0;
      prev_cnt_nxt = '0;
      full_nxt     = 1'b0;
      vld_a_nxt    = '0;
      vld_b_nxt    = '0;
    end

    out_valid_nxt = out_valid_r & ~out_ch.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cols_r      <= '0;
      rows_r      <= '0;
      cur_b_r     <= 1'b0;
      curr_cnt_r  <= '0;
      prev_cnt_r  <= '0;
      full_r      <= 1'b0;
      vld_a_r     <= '0;
      vld_b_r     <= '0;
      pc_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      cur_b_r     <= cur_b_nxt;
      curr_cnt_r  <= curr_cnt_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      full_r      <= full_nxt;
      vld_a_r     <= vld_a_nxt;
      vld_b_r     <= vld_b_nxt;
      pc_pend_r   <= pc_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    cx0_r   <= cx0_nxt;
    cx1_r   <= cx1_nxt;
    cy_r    <= cy_nxt;
    cy1_r   <= cy1_nxt;
    base_r  <= base_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    wcur_r  <= wcur_nxt;
    total_r <= total_nxt;
    pbit_r  <= pbit_nxt;
    cbit_r  <= cbit_nxt;
    for (int i = 0; i < WORD_BYTES; i++) begin
      pc_bytes_r[i] <= pc_bytes_nxt[i];
    end
    // Totals are taken from the next-state values so that a count still
    // in flight from the last word write is included.
    if (load_out) begin
      o_prev_r <= pbit_r;
      o_curr_r <= cbit_r;
      o_ctot_r <= curr_cnt_nxt;
      o_ptot_r <= prev_cnt_nxt;
      o_all_r  <= full_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Tile map memories: one write and one registered read per cycle each.
  // A word whose valid bit is clear reads as all zero.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wcur_r] <= wdata;
    end
    rdata_a_r <= mem_a[wcur_r];
    rvld_a_r  <= vld_a_r[wcur_r];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wcur_r] <= wdata;
    end
    rdata_b_r <= mem_b[wcur_r];
    rvld_b_r  <= vld_b_r[wcur_r];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prev_dirty  = o_prev_r;
  assign out_ch.curr_marked = o_curr_r;
  assign out_ch.curr_total  = o_ctot_r;
  assign out_ch.prev_total  = o_ptot_r;
  assign out_ch.all_dirty   = o_all_r;

`ifndef SYNTHESIS
  // A grid size write leaves nothing counted and the flag down.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (curr_cnt_r == '0) && (prev_cnt_r == '0) && !full_r)
    else $error("grid write did not clear counts and flag");

  // The current map's count never exceeds its number of entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    curr_cnt_r <= CNT_W'(MAP_DEPTH))
    else $error("current count beyond map depth");

  // A swap on a live grid exchanges the maps when no grid write comes in that cycle.
  a_swap_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) && (cmd_r == CMD_SWAP) && grid_ok && !cfg_we
      |=> cur_b_r != $past(cur_b_r))
    else $error("swap did not exchange maps");

  // Every write-back is preceded by the read of its word.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ($past(state_r) == S_RD))
    else $error("word write-back without a prior read");
`endif

endmodule

`default_nettype wire

### test/tb_dirty_tile_tracker.sv
`timescale 1ns / 1ps

module tb_dirty_tile_tracker;
  import dtt_pkg::*;

  // Command codes above CMD_QUERY are reserved; the block must leave its state
  // alone for them and still report the totals.
  localparam cmd_t CMD_SPARE_LO = 3'd5;
  localparam cmd_t CMD_SPARE_HI = 3'd7;

  // The slowest legal command is a tall rectangle that straddles map words;
  // nothing else keeps both channels silent anywhere near as long.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PLAN_PHASES    = 10;

  // One command as the sender presents it. It is unpacked so that the
  // rectangle fields keep their sign when they are read one at a time.
  typedef struct {
    cmd_t  cmd;
    pix_t  rect_x;
    pix_t  rect_y;
    pix_t  rect_w;
    pix_t  rect_h;
    cell_t cell_col;
    cell_t cell_row;
  } tile_cmd_t;

  // One result transfer, field by field.
  typedef struct packed {
    logic prev_dirty;
    logic curr_marked;
    cnt_t curr_total;
    cnt_t prev_total;
    logic all_dirty;
  } tile_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dtt_cmd_if cmd_ch ();
  dtt_res_if res_ch ();

  dirty_tile_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the tracker. The two maps live in one array; frame_sel says
  // which of the two is the current frame, the other one is the previous.
  // ---------------------------------------------------------------------------
  bit          tile_bits [2][MAP_DEPTH];
  bit          frame_sel;
  cnt_t        marked_now;
  cnt_t        marked_before;
  bit          screen_full;
  int unsigned cols_in_use;
  int unsigned rows_in_use;

  tile_cmd_t    pending_cmds [$];
  tile_report_t expected_reports [$];

  bit          cmd_taken;
  int unsigned error_count;
  int unsigned reports_checked;
  int unsigned grid_writes;
  int unsigned stuck_cycles;
  int unsigned cmd_seen [8];
  int unsigned plan_cols [PLAN_PHASES];
  int unsigned plan_rows [PLAN_PHASES];

  function automatic void clear_frame(input bit which);
    int unsigned i;
    for (i = 0; i < MAP_DEPTH; i++) tile_bits[which][i] = 1'b0;
  endfunction

  // Sets one tile in the current frame; only a clear-to-set change counts.
  function automatic void mark_tile(input int unsigned col, input int unsigned row);
    int unsigned idx;
    idx = row * cols_in_use + col;
    if (idx < MAP_DEPTH && !tile_bits[frame_sel][idx]) begin
      tile_bits[frame_sel][idx] = 1'b1;
      marked_now = marked_now + 1'b1;
    end
  endfunction

  // Works out what one accepted command does to the shadow state and which
  // result the block must send back for it.
  function automatic tile_report_t apply_tile_cmd(input tile_cmd_t c);
    tile_report_t rep;
    int          left, top, right, bottom, width, height;
    int unsigned col, row, tiles, idx;
    bit          grid_ok;
    rep = '0;
    grid_ok = (cols_in_use != 0) && (rows_in_use != 0);
    case (c.cmd)
      CMD_MARK_RECT: begin
        width  = c.rect_w;
        height = c.rect_h;
        if (grid_ok && width > 0 && height > 0) begin
          // Clip the pixel rectangle to the grid, then walk the covered tiles.
          left   = (c.rect_x < 0) ? 0 : int'(c.rect_x);
          top    = (c.rect_y < 0) ? 0 : int'(c.rect_y);
          right  = int'(c.rect_x) + width - 1;
          bottom = int'(c.rect_y) + height - 1;
          if (right > int'(cols_in_use) * CELL_WIDTH - 1)
            right = int'(cols_in_use) * CELL_WIDTH - 1;
          if (bottom > int'(rows_in_use) * CELL_HEIGHT - 1)
            bottom = int'(rows_in_use) * CELL_HEIGHT - 1;
          if (left <= right && top <= bottom) begin
            for (row = top / CELL_HEIGHT; row <= bottom / CELL_HEIGHT; row++)
              for (col = left / CELL_WIDTH; col <= right / CELL_WIDTH; col++)
                mark_tile(col, row);
          end
        end
      end
      CMD_MARK_CELL: begin
        if (c.cell_col < cols_in_use && c.cell_row < rows_in_use)
          mark_tile(c.cell_col, c.cell_row);
      end
      CMD_MARK_ALL: begin
        // The sticky flag rises even on an empty grid.
        screen_full = 1'b1;
        if (grid_ok) begin
          tiles = cols_in_use * rows_in_use;
          if (tiles > MAP_DEPTH) tiles = MAP_DEPTH;
          for (idx = 0; idx < tiles; idx++) tile_bits[frame_sel][idx] = 1'b1;
          marked_now = cnt_t'(tiles);
        end
      end
      CMD_SWAP: begin
        if (grid_ok) begin
          frame_sel     = !frame_sel;
          marked_before = marked_now;
          clear_frame(frame_sel);
          marked_now    = '0;
        end
      end
      CMD_QUERY: begin
        if (c.cell_col < cols_in_use && c.cell_row < rows_in_use) begin
          idx = c.cell_row * cols_in_use + c.cell_col;
          if (idx < MAP_DEPTH) begin
            rep.prev_dirty  = tile_bits[!frame_sel][idx];
            rep.curr_marked = tile_bits[frame_sel][idx];
          end
        end
      end
      default: begin
      end
    endcase
    rep.curr_total = marked_now;
    rep.prev_total = marked_before;
    rep.all_dirty  = screen_full;
    return rep;
  endfunction

  function automatic tile_cmd_t make_cmd(input cmd_t op, input int x, input int y,
                                         input int w, input int h,
                                         input int unsigned col, input int unsigned row);
    tile_cmd_t c;
    c.cmd      = op;
    c.rect_x   = pix_t'(x);
    c.rect_y   = pix_t'(y);
    c.rect_w   = pix_t'(w);
    c.rect_h   = pix_t'(h);
    c.cell_col = cell_t'(col);
    c.cell_row = cell_t'(row);
    return c;
  endfunction

  // Random command shaped for the current grid: rectangles mostly small and
  // around the visible area, tiles mostly inside the grid, and some noise
  // where every field is fully random.
  function automatic tile_cmd_t random_tile_cmd();
    tile_cmd_t   c;
    int unsigned pick, span_x, span_y;
    pick   = $urandom_range(0, 99);
    span_x = (cols_in_use == 0 ? 8 : cols_in_use) * CELL_WIDTH;
    span_y = (rows_in_use == 0 ? 8 : rows_in_use) * CELL_HEIGHT;
    c.cmd      = cmd_t'($urandom);
    c.rect_x   = pix_t'($urandom);
    c.rect_y   = pix_t'($urandom);
    c.rect_w   = pix_t'($urandom);
    c.rect_h   = pix_t'($urandom);
    c.cell_col = cell_t'($urandom);
    c.cell_row = cell_t'($urandom);
    if (pick >= 95) return c;
    if (cols_in_use != 0 && $urandom_range(0, 7) != 0)
      c.cell_col = cell_t'($urandom_range(0, cols_in_use - 1));
    if (rows_in_use != 0 && $urandom_range(0, 7) != 0)
      c.cell_row = cell_t'($urandom_range(0, rows_in_use - 1));
    if (pick < 30) begin
      c.cmd    = CMD_MARK_RECT;
      c.rect_x = pix_t'($urandom_range(0, span_x + 32) - 16);
      c.rect_y = pix_t'($urandom_range(0, span_y + 32) - 16);
      case ($urandom_range(0, 9))
        7, 8:    c.rect_w = pix_t'($urandom_range(1, span_x + 16));
        9:       ;
        default: c.rect_w = pix_t'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        7, 8:    c.rect_h = pix_t'($urandom_range(1, span_y + 16));
        9:       ;
        default: c.rect_h = pix_t'($urandom_range(1, 24));
      endcase
    end else if (pick < 50) begin
      c.cmd = CMD_MARK_CELL;
    end else if (pick < 75) begin
      c.cmd = CMD_QUERY;
    end else if (pick < 85) begin
      c.cmd = CMD_SWAP;
    end else if (pick < 90) begin
      c.cmd = CMD_MARK_ALL;
    end else begin
      c.cmd = cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return c;
  endfunction

  // APB write: a setup phase, then an access phase that completes at the
  // first rising edge with pready high. Any write clears the whole tracker.
  task automatic write_grid_reg(input logic which, input int unsigned value);
    int unsigned size;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {which, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    size = value & 32'h7F;
    if (which == REG_GRID_COLS) cols_in_use = (size > MAX_COLS) ? MAX_COLS : size;
    else rows_in_use = (size > MAX_ROWS) ? MAX_ROWS : size;
    clear_frame(1'b0);
    clear_frame(1'b1);
    frame_sel     = 1'b0;
    marked_now    = '0;
    marked_before = '0;
    screen_full   = 1'b0;
    grid_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Holds the caller back until every queued command has gone out and every
  // result has come back, so the block is idle afterwards.
  task automatic wait_for_drain();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_reports.size() != 0)
      @(posedge clk);
  endtask

  // Writes both grid registers in random order. Half of the writes carry
  // junk above the seven register bits, which the block must drop.
  task automatic set_grid(input int unsigned cols, input int unsigned rows);
    int unsigned junk_c, junk_r;
    junk_c = $urandom_range(0, 1) ? ($urandom & 32'hFFFF_FF80) : 0;
    junk_r = $urandom_range(0, 1) ? ($urandom & 32'hFFFF_FF80) : 0;
    if ($urandom_range(0, 1)) begin
      write_grid_reg(REG_GRID_COLS, cols | junk_c);
      write_grid_reg(REG_GRID_ROWS, rows | junk_r);
    end else begin
      write_grid_reg(REG_GRID_ROWS, rows | junk_r);
      write_grid_reg(REG_GRID_COLS, cols | junk_c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command driver. It works in bursts of random length separated by random
  // gaps; a gap of zero gives back-to-back bursts. The payload changes only
  // at the falling edge and only once the last command has been taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned send_gap;

  always @(negedge clk) begin
    tile_cmd_t nxt;
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        cmd_ch.cmd      <= nxt.cmd;
        cmd_ch.rect_x   <= nxt.rect_x;
        cmd_ch.rect_y   <= nxt.rect_y;
        cmd_ch.rect_w   <= nxt.rect_w;
        cmd_ch.rect_h   <= nxt.rect_h;
        cmd_ch.cell_col <= nxt.cell_col;
        cmd_ch.cell_row <= nxt.cell_row;
        cmd_ch.valid    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. ready follows a 16-bit pattern that rotates every cycle
  // and is reloaded whenever the phase counter wraps: always ready, random,
  // or mostly stalled. Bit 0 is forced high so no stall lasts a whole pass.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pattern;
  logic [5:0]  ready_phase;

  always @(negedge clk) begin
    if (ready_phase == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pattern = 16'hFFFF;
        1:       stall_pattern = 16'($urandom) | 16'h0001;
        default: stall_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
      endcase
    end
    res_ch.ready <= rst_n && stall_pattern[ready_phase[3:0]];
    ready_phase  = ready_phase + 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge it first checks a result transfer against
  // the oldest expectation, then feeds an accepted command to the shadow
  // model. A result never leaves in the cycle its command is taken, so the
  // order of the two steps cannot matter. The watchdog counts edges at which
  // neither channel moves a transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tile_report_t want;
    tile_cmd_t    got;
    if (!rst_n) begin
      cmd_taken    <= 1'b0;
      stuck_cycles = 0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no command outstanding");
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (res_ch.prev_dirty !== want.prev_dirty) begin
            $error("prev_dirty: expected %0d, actual %0d", want.prev_dirty, res_ch.prev_dirty);
            error_count++;
          end
          if (res_ch.curr_marked !== want.curr_marked) begin
            $error("curr_marked: expected %0d, actual %0d",
                   want.curr_marked, res_ch.curr_marked);
            error_count++;
          end
          if (res_ch.curr_total !== want.curr_total) begin
            $error("curr_total: expected %0d, actual %0d", want.curr_total, res_ch.curr_total);
            error_count++;
          end
          if (res_ch.prev_total !== want.prev_total) begin
            $error("prev_total: expected %0d, actual %0d", want.prev_total, res_ch.prev_total);
            error_count++;
          end
          if (res_ch.all_dirty !== want.all_dirty) begin
            $error("all_dirty: expected %0d, actual %0d", want.all_dirty, res_ch.all_dirty);
            error_count++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        got.cmd      = cmd_ch.cmd;
        got.rect_x   = cmd_ch.rect_x;
        got.rect_y   = cmd_ch.rect_y;
        got.rect_w   = cmd_ch.rect_w;
        got.rect_h   = cmd_ch.rect_h;
        got.cell_col = cmd_ch.cell_col;
        got.cell_row = cmd_ch.cell_row;
        expected_reports.push_back(apply_tile_cmd(got));
        cmd_seen[got.cmd]++;
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 stuck_cycles, expected_reports.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, a directed part on the empty grid and on the full
  // 64 x 64 grid, then random phases over a range of grid sizes. Each phase
  // starts from an idle block, so the grid writes never race a command.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, n, phase_items;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.cmd      = CMD_QUERY;
    cmd_ch.rect_x   = '0;
    cmd_ch.rect_y   = '0;
    cmd_ch.rect_w   = '0;
    cmd_ch.rect_h   = '0;
    cmd_ch.cell_col = '0;
    cmd_ch.cell_row = '0;
    res_ch.ready    = 1'b0;
    stall_pattern   = 16'hFFFF;
    ready_phase     = '0;
    burst_left      = 0;
    send_gap        = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // The grid is 0 x 0 after reset: everything is a no-op except that
    // mark_all still raises the sticky flag.
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, 0, 0, 16, 16, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_CELL, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SWAP, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_ALL, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    wait_for_drain();

    set_grid(MAX_COLS, MAX_ROWS);
    // Rectangles that clip to nothing, have no area, or hang off the edges.
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, -32768, -32768, 32767, 32767, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, 32767, 32767, 32767, 32767, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, 0, 0, 0, 5, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, 0, 0, 5, -32768, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, -5, -3, 20, 12, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_RECT, 500, 500, 32767, 32767, 0, 0));
    // Single tiles: outside the grid, the far corner, and one already set.
    pending_cmds.push_back(make_cmd(CMD_MARK_CELL, 0, 0, 0, 0, 255, 255));
    pending_cmds.push_back(make_cmd(CMD_MARK_CELL, 0, 0, 0, 0, 63, 63));
    pending_cmds.push_back(make_cmd(CMD_MARK_CELL, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 255, 255));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 63, 63));
    pending_cmds.push_back(make_cmd(CMD_SWAP, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SPARE_LO, -1, -1, -1, -1, 255, 255));
    pending_cmds.push_back(make_cmd(CMD_SPARE_HI, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_MARK_ALL, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 10, 10));
    pending_cmds.push_back(make_cmd(CMD_SWAP, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 10, 10));
    wait_for_drain();

    // Grid sizes for the random phases: both extremes, a saturating write,
    // each dimension empty on its own, thin strips, and two random sizes.
    plan_cols = '{64, 1, 127, 0, 40, 13, 64, 2,
                  $urandom_range(1, MAX_COLS), $urandom_range(0, 127)};
    plan_rows = '{64, 1, 100, 40, 0, 7, 3, 64,
                  $urandom_range(1, MAX_ROWS), $urandom_range(0, 127)};
    for (phase = 0; phase < PLAN_PHASES; phase++) begin
      set_grid(plan_cols[phase], plan_rows[phase]);
      phase_items = (cols_in_use == 0 || rows_in_use == 0) ? 40 : 125;
      for (n = 0; n < phase_items; n++) pending_cmds.push_back(random_tile_cmd());
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d rect, %0d cell, %0d mark-all, %0d swap, %0d query, %0d reserved cmds",
             cmd_seen[CMD_MARK_RECT], cmd_seen[CMD_MARK_CELL], cmd_seen[CMD_MARK_ALL],
             cmd_seen[CMD_SWAP], cmd_seen[CMD_QUERY],
             cmd_seen[CMD_SPARE_LO] + cmd_seen[6] + cmd_seen[CMD_SPARE_HI]);
    $display("across %0d grid register writes; %0d results compared, %0d mismatches",
             grid_writes, reports_checked, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hdl/dtt_pkg.sv
hdl/dtt_cmd_if.sv
hdl/dtt_res_if.sv
hdl/dirty_tile_tracker.sv
test/tb_dirty_tile_tracker.sv
